// ----- rtl/rlsv_pkg.sv -----
// Shared constants, types and functions for the record log scan validator.
`default_nettype none
package rlsv_pkg;

	// Offset counter width and the offset of the first journal byte.
	localparam int OFF_W        = 48;
	localparam int HEADER_BYTES = 16;

	typedef logic [OFF_W-1:0] offset_t;
	typedef logic [47:0]      out48_t;

	// CRC-32C, reflected form.
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

	localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

	// Input function codes.
	localparam logic FUNC_END = 1'b1;

	// Result kinds.
	localparam logic KIND_RECORD  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Stop reasons.
	localparam logic [2:0] STOP_CLEAN     = 3'd0;
	localparam logic [2:0] STOP_TRUNCATED = 3'd1;
	localparam logic [2:0] STOP_ZERO_LEN  = 3'd2;
	localparam logic [2:0] STOP_TOO_LONG  = 3'd3;
	localparam logic [2:0] STOP_CRC       = 3'd4;

	// Advance the CRC by one byte, one polynomial step per bit.
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// Fit an offset into a 48-bit output field.
	function automatic out48_t to_out48(input offset_t v);
		logic [63:0] wide;
		wide = 64'(v);
		return wide[47:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rlsv_if.sv -----
// Channel interfaces of the record log scan validator: input, result and configuration.
`default_nettype none
interface rlsv_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] data_byte;

	modport source (output valid, output func, output data_byte, input ready);
	modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface rlsv_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [47:0] offset;
	logic [31:0] record_length;
	logic [47:0] tail_bytes;
	logic [2:0]  stop_reason;

	modport source (output valid, output kind, output offset, output record_length,
		output tail_bytes, output stop_reason, input ready);
	modport sink   (input valid, input kind, input offset, input record_length,
		input tail_bytes, input stop_reason, output ready);
endinterface

interface rlsv_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/record_log_scan_validator_top.sv -----
// Record log scan validator: record framing and CRC-32C check of a journal byte stream.
// An accepted transaction moves through the input stage register, then the result register shown on out_ch.
// Throughput: one input transaction per cycle unless a held result stalls the input stage; the byte-wise
// CRC update and the counters all settle between the input stage register and the result register.
// Reset (arst_n low, asynchronous): scan state to record-header phase at offset 16,
// CRC to all ones, max_record_length to 1048576, both stages empty.
`default_nettype none
module record_log_scan_validator_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rlsv_in_if.sink     in_ch,
	rlsv_out_if.source  out_ch,
	rlsv_cfg_if.sink    cfg
);

	// Scan phase codes.
	localparam logic [1:0] PH_HEAD = 2'd0;
	localparam logic [1:0] PH_BODY = 2'd1;
	localparam logic [1:0] PH_STOP = 2'd2;

	// Input stage.
	logic       valid_s1;
	logic       func_s1;
	logic [7:0] byte_s1;

	// Configuration.
	logic [31:0] max_len_q;

	// Scan state.
	logic [1:0]       phase_q,     phase_d;
	logic [2:0]       hdr_cnt_q,   hdr_cnt_d;
	logic [31:0]      length_q,    length_d;
	logic [31:0]      exp_crc_q,   exp_crc_d;
	logic [31:0]      crc_q,       crc_d;
	logic [31:0]      remain_q,    remain_d;
	rlsv_pkg::offset_t rec_start_q, rec_start_d;
	rlsv_pkg::offset_t position_q,  position_d;
	logic [2:0]       stop_q,      stop_d;

	// Result register.
	logic        res_valid_q;
	logic        res_kind_q,   res_kind_d;
	logic [47:0] res_offset_q, res_offset_d;
	logic [31:0] res_len_q,    res_len_d;
	logic [47:0] res_tail_q,   res_tail_d;
	logic [2:0]  res_reason_q, res_reason_d;
	logic        load_res;

	logic        proc;
	logic [31:0] crc_next;
	logic [4:0]  byte_shift;

	// Work on the staged transaction whenever the result register is free or draining.
	assign proc        = valid_s1 && (!res_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || proc;
	assign cfg.ready   = 1'b1;

	assign crc_next   = rlsv_pkg::crc32c_byte(crc_q, byte_s1);
	assign byte_shift = {hdr_cnt_q[1:0], 3'b000};

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			func_s1 <= in_ch.func;
			byte_s1 <= in_ch.data_byte;
		end
	end

	// Length limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= rlsv_pkg::MAX_LEN_RESET;
		end else if (cfg.valid) begin
			max_len_q <= cfg.data;
		end
	end

	// Next scan state and result for the staged transaction.
	always_comb begin
		phase_d      = phase_q;
		hdr_cnt_d    = hdr_cnt_q;
		length_d     = length_q;
		exp_crc_d    = exp_crc_q;
		crc_d        = crc_q;
		remain_d     = remain_q;
		rec_start_d  = rec_start_q;
		position_d   = position_q;
		stop_d       = stop_q;
		load_res     = 1'b0;
		res_kind_d   = rlsv_pkg::KIND_RECORD;
		res_offset_d = rlsv_pkg::to_out48(rec_start_q);
		res_len_d    = length_q;
		res_tail_d   = '0;
		res_reason_d = rlsv_pkg::STOP_CLEAN;

		if (proc) begin
			if (func_s1 == rlsv_pkg::FUNC_END) begin
				// End of file: report the summary, then start over for a new file.
				load_res   = 1'b1;
				res_kind_d = rlsv_pkg::KIND_SUMMARY;
				res_len_d  = '0;
				res_tail_d = rlsv_pkg::to_out48(position_q - rec_start_q);
				if (phase_q == PH_STOP) begin
					res_reason_d = stop_q;
				end else if (phase_q == PH_HEAD && hdr_cnt_q == 3'd0) begin
					res_reason_d = rlsv_pkg::STOP_CLEAN;
				end else begin
					res_reason_d = rlsv_pkg::STOP_TRUNCATED;
				end
				phase_d     = PH_HEAD;
				hdr_cnt_d   = '0;
				length_d    = '0;
				exp_crc_d   = '0;
				crc_d       = rlsv_pkg::CRC_INIT;
				remain_d    = '0;
				rec_start_d = rlsv_pkg::offset_t'(rlsv_pkg::HEADER_BYTES);
				position_d  = rlsv_pkg::offset_t'(rlsv_pkg::HEADER_BYTES);
				stop_d      = rlsv_pkg::STOP_CLEAN;
			end else begin
				case (phase_q)
					PH_HEAD: begin
						// Length bytes feed the CRC; CRC bytes are only collected.
						if (!hdr_cnt_q[2]) begin
							length_d = length_q | (32'(byte_s1) << byte_shift);
							crc_d    = crc_next;
						end else begin
							exp_crc_d = exp_crc_q | (32'(byte_s1) << byte_shift);
						end
						if (hdr_cnt_q == 3'd7) begin
							hdr_cnt_d = '0;
							if (length_q == '0) begin
								phase_d = PH_STOP;
								stop_d  = rlsv_pkg::STOP_ZERO_LEN;
							end else if (length_q > max_len_q) begin
								phase_d = PH_STOP;
								stop_d  = rlsv_pkg::STOP_TOO_LONG;
							end else begin
								phase_d  = PH_BODY;
								remain_d = length_q;
							end
						end else begin
							hdr_cnt_d = hdr_cnt_q + 3'd1;
						end
					end
					PH_BODY: begin
						crc_d    = crc_next;
						remain_d = remain_q - 32'd1;
						if (remain_q == 32'd1) begin
							if ((crc_next ^ rlsv_pkg::CRC_INIT) != exp_crc_q) begin
								phase_d = PH_STOP;
								stop_d  = rlsv_pkg::STOP_CRC;
							end else begin
								// Good record: report it and open the next one.
								load_res    = 1'b1;
								rec_start_d = position_q + rlsv_pkg::offset_t'(1);
								phase_d     = PH_HEAD;
								hdr_cnt_d   = '0;
								length_d    = '0;
								exp_crc_d   = '0;
								crc_d       = rlsv_pkg::CRC_INIT;
							end
						end
					end
					default: begin
						// Stopped: bytes only count toward the tail.
					end
				endcase
				position_d = position_q + rlsv_pkg::offset_t'(1);
			end
		end
	end

	// Scan state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEAD;
			hdr_cnt_q   <= '0;
			length_q    <= '0;
			exp_crc_q   <= '0;
			crc_q       <= rlsv_pkg::CRC_INIT;
			remain_q    <= '0;
			rec_start_q <= rlsv_pkg::offset_t'(rlsv_pkg::HEADER_BYTES);
			position_q  <= rlsv_pkg::offset_t'(rlsv_pkg::HEADER_BYTES);
			stop_q      <= rlsv_pkg::STOP_CLEAN;
		end else begin
			phase_q     <= phase_d;
			hdr_cnt_q   <= hdr_cnt_d;
			length_q    <= length_d;
			exp_crc_q   <= exp_crc_d;
			crc_q       <= crc_d;
			remain_q    <= remain_d;
			rec_start_q <= rec_start_d;
			position_q  <= position_d;
			stop_q      <= stop_d;
		end
	end

	// Result register: hold until taken, load when a transaction yields a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_kind_q   <= res_kind_d;
			res_offset_q <= res_offset_d;
			res_len_q    <= res_len_d;
			res_tail_q   <= res_tail_d;
			res_reason_q <= res_reason_d;
		end
	end

	assign out_ch.valid         = res_valid_q;
	assign out_ch.kind          = res_kind_q;
	assign out_ch.offset        = res_offset_q;
	assign out_ch.record_length = res_len_q;
	assign out_ch.tail_bytes    = res_tail_q;
	assign out_ch.stop_reason   = res_reason_q;

endmodule
`default_nettype wire

// ----- rtl/rlsv_checker.sv -----
// Port-level assertions for the record log scan validator and their bind.
`default_nettype none
module rlsv_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        kind,
	input wire logic [47:0] offset,
	input wire logic [31:0] record_length,
	input wire logic [47:0] tail_bytes,
	input wire logic [2:0]  stop_reason
);

	// A stalled result transaction holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(offset) && $stable(kind)
			&& $stable(record_length) && $stable(tail_bytes) && $stable(stop_reason))
		else $error("result changed while stalled");

	// Record results carry no tail and no reason.
	a_record_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == rlsv_pkg::KIND_RECORD |->
			tail_bytes == 48'd0 && stop_reason == rlsv_pkg::STOP_CLEAN)
		else $error("record result with tail or reason");

	// Record results never report an empty payload.
	a_record_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == rlsv_pkg::KIND_RECORD |-> record_length != 32'd0)
		else $error("record result with zero length");

	// Summaries carry no length and a defined reason.
	a_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == rlsv_pkg::KIND_SUMMARY |->
			record_length == 32'd0 && stop_reason <= rlsv_pkg::STOP_CRC)
		else $error("malformed summary result");

endmodule

bind record_log_scan_validator_top rlsv_checker u_rlsv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.kind          (out_ch.kind),
	.offset        (out_ch.offset),
	.record_length (out_ch.record_length),
	.tail_bytes    (out_ch.tail_bytes),
	.stop_reason   (out_ch.stop_reason)
);
`default_nettype wire

// ----- test/record_log_scan_validator_top_test.sv -----
// Self-checking testbench of the record log scan validator: framed journals, CRC faults, stalls.
`default_nettype none
module record_log_scan_validator_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	// Scan phases of the expected-report model; the package has no names for them.
	typedef enum logic [1:0] {
		SCAN_HEADER,
		SCAN_PAYLOAD,
		SCAN_STOPPED
	} scan_phase_t;

	// One report as it appears on the result channel.
	typedef struct {
		logic             kind;
		rlsv_pkg::out48_t offset;
		logic [31:0]      record_length;
		rlsv_pkg::out48_t tail_bytes;
		logic [2:0]       stop_reason;
	} scan_report_t;

	// One input transaction: a journal byte or the end-of-file mark.
	typedef struct {
		logic       func;
		logic [7:0] data_byte;
	} journal_item_t;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic [31:0] LEN_CEILING = 32'hFFFF_FFFF;

	// Record framing model plus the queue of reports it predicts.
	class record_scan_checker;
		logic [31:0]       max_len;
		scan_phase_t       phase;
		logic [2:0]        hdr_count;
		logic [31:0]       len_acc;
		logic [31:0]       crc_field;
		logic [31:0]       crc_run;
		logic [31:0]       remaining;
		rlsv_pkg::offset_t rec_start;
		rlsv_pkg::offset_t pos;
		logic [2:0]        stop_code;
		scan_report_t      expected_reports[$];
		int                failures;

		function new();
			max_len  = rlsv_pkg::MAX_LEN_RESET;
			failures = 0;
			restart();
		endfunction

		static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
			logic fb;
			for (int i = 0; i < 8; i++) begin
				fb = c[0] ^ b[i];
				c  = c >> 1;
				if (fb) begin
					c = c ^ rlsv_pkg::CRC_POLY;
				end
			end
			return c;
		endfunction

		function void restart();
			phase     = SCAN_HEADER;
			hdr_count = '0;
			len_acc   = '0;
			crc_field = '0;
			crc_run   = rlsv_pkg::CRC_INIT;
			remaining = '0;
			rec_start = rlsv_pkg::offset_t'(rlsv_pkg::HEADER_BYTES);
			pos       = rec_start;
			stop_code = rlsv_pkg::STOP_CLEAN;
		endfunction

		function void fail(string msg);
			failures++;
			if (failures <= 10) begin
				$display("%s", msg);
			end
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		function void note_item(logic func, logic [7:0] b);
			scan_report_t r;
			if (func == rlsv_pkg::FUNC_END) begin
				r.kind          = rlsv_pkg::KIND_SUMMARY;
				r.offset        = rlsv_pkg::out48_t'(rec_start);
				r.record_length = '0;
				r.tail_bytes    = rlsv_pkg::out48_t'(pos - rec_start);
				if (phase == SCAN_STOPPED) begin
					r.stop_reason = stop_code;
				end else if (phase == SCAN_HEADER && hdr_count == 0) begin
					r.stop_reason = rlsv_pkg::STOP_CLEAN;
				end else begin
					r.stop_reason = rlsv_pkg::STOP_TRUNCATED;
				end
				expected_reports.insert(expected_reports.size(), r);
				restart();
				return;
			end
			case (phase)
				SCAN_HEADER: begin
					if (hdr_count < 4) begin
						len_acc |= 32'(b) << (8 * hdr_count);
						crc_run = crc_step(crc_run, b);
					end else begin
						crc_field |= 32'(b) << (8 * (hdr_count - 4));
					end
					if (hdr_count == 3'd7) begin
						hdr_count = '0;
						if (len_acc == 0) begin
							phase     = SCAN_STOPPED;
							stop_code = rlsv_pkg::STOP_ZERO_LEN;
						end else if (len_acc > max_len) begin
							phase     = SCAN_STOPPED;
							stop_code = rlsv_pkg::STOP_TOO_LONG;
						end else begin
							phase     = SCAN_PAYLOAD;
							remaining = len_acc;
						end
					end else begin
						hdr_count++;
					end
				end
				SCAN_PAYLOAD: begin
					crc_run = crc_step(crc_run, b);
					remaining--;
					if (remaining == 0) begin
						if (~crc_run != crc_field) begin
							phase     = SCAN_STOPPED;
							stop_code = rlsv_pkg::STOP_CRC;
						end else begin
							r.kind          = rlsv_pkg::KIND_RECORD;
							r.offset        = rlsv_pkg::out48_t'(rec_start);
							r.record_length = len_acc;
							r.tail_bytes    = '0;
							r.stop_reason   = rlsv_pkg::STOP_CLEAN;
							expected_reports.insert(expected_reports.size(), r);
							rec_start = pos + 1'b1;
							phase     = SCAN_HEADER;
							hdr_count = '0;
							len_acc   = '0;
							crc_field = '0;
							crc_run   = rlsv_pkg::CRC_INIT;
						end
					end
				end
				default: ;
			endcase
			pos = pos + 1'b1;
		endfunction

		function void check_report(scan_report_t got);
			scan_report_t want;
			if (expected_reports.size() == 0) begin
				fail($sformatf("unexpected report: kind %0d offset %0d length %0d tail %0d reason %0d",
					got.kind, got.offset, got.record_length, got.tail_bytes, got.stop_reason));
			end else begin
				want = expected_reports.pop_front();
				if (got.kind !== want.kind || got.offset !== want.offset ||
						got.record_length !== want.record_length ||
						got.tail_bytes !== want.tail_bytes ||
						got.stop_reason !== want.stop_reason) begin
					fail($sformatf({"report mismatch: expected kind %0d offset %0d length %0d",
						" tail %0d reason %0d, got kind %0d offset %0d length %0d tail %0d reason %0d"},
						want.kind, want.offset, want.record_length, want.tail_bytes,
						want.stop_reason, got.kind, got.offset, got.record_length,
						got.tail_bytes, got.stop_reason));
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rlsv_in_if  in_ch ();
	rlsv_out_if out_ch ();
	rlsv_cfg_if cfg ();

	record_log_scan_validator_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	always #2 clk = ~clk;

	record_scan_checker sb = new();
	journal_item_t      journal_q[$];
	int                 in_accepted = 0;
	int                 tx_quiet = 0;
	int                 rx_quiet = 0;
	bit                 hold_active = 1'b0;

	// Pick an idle gap: mostly none or short, now and then long, with quiet
	// stretches in which no gap is taken at all.
	function automatic int next_gap(inout int quiet_left);
		int r;
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			quiet_left = $urandom_range(20, 60);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 50);
	endfunction

	// ---------------------------------------------------------------
	// Journal building: append transactions to journal_q.
	// ---------------------------------------------------------------
	task automatic push_byte(input logic [7:0] b);
		journal_item_t it;
		it.func      = FUNC_BYTE;
		it.data_byte = b;
		journal_q.insert(journal_q.size(), it);
	endtask

	task automatic push_end(input logic [7:0] b);
		journal_item_t it;
		it.func      = rlsv_pkg::FUNC_END;
		it.data_byte = b;
		journal_q.insert(journal_q.size(), it);
	endtask

	// Header only: little-endian length, then little-endian CRC.
	task automatic push_header(input logic [31:0] len, input logic [31:0] crc);
		for (int i = 0; i < 4; i++) begin
			push_byte(len[8*i +: 8]);
		end
		for (int i = 0; i < 4; i++) begin
			push_byte(crc[8*i +: 8]);
		end
	endtask

	// Full record with random payload; flip one CRC bit when asked, and
	// emit only the first keep bytes when keep is not negative.
	task automatic push_record(input logic [31:0] len, input bit bad_crc, input int keep);
		logic [7:0]  rec[$];
		logic [7:0]  body[$];
		logic [31:0] c;
		c = rlsv_pkg::CRC_INIT;
		for (int i = 0; i < 4; i++) begin
			rec.insert(rec.size(), len[8*i +: 8]);
			c = record_scan_checker::crc_step(c, len[8*i +: 8]);
		end
		for (int unsigned i = 0; i < len; i++) begin
			body.insert(body.size(), 8'($urandom));
			c = record_scan_checker::crc_step(c, body[i]);
		end
		c = ~c;
		if (bad_crc) begin
			c ^= 32'h1 << $urandom_range(0, 31);
		end
		for (int i = 0; i < 4; i++) begin
			rec.insert(rec.size(), c[8*i +: 8]);
		end
		foreach (body[i]) begin
			rec.insert(rec.size(), body[i]);
		end
		if (keep < 0 || keep > rec.size()) begin
			keep = rec.size();
		end
		for (int i = 0; i < keep; i++) begin
			push_byte(rec[i]);
		end
	endtask

	// Payload length that a nonzero limit accepts; sometimes exactly the limit.
	function automatic logic [31:0] fit_len(input logic [31:0] lim);
		logic [31:0] cap;
		cap = (lim == 0) ? 32'd1 : ((lim < 24) ? lim : 32'd24);
		if (lim != 0 && lim <= 64 && $urandom_range(0, 9) == 0) begin
			return lim;
		end
		return $urandom_range(1, cap);
	endfunction

	// One journal file: a few records, mostly well formed, the rest broken in
	// one of the ways that stop the scan, then bytes after any stop and the end mark.
	task automatic gen_file(input logic [31:0] lim);
		int          nrec;
		int          pick;
		int          cut;
		logic [31:0] len;
		bit          stopped;
		stopped = 1'b0;
		nrec    = $urandom_range(0, 4);
		for (int k = 0; k < nrec && !stopped; k++) begin
			pick = $urandom_range(0, 99);
			// no payload fits a zero limit: turn full records into too-long ones
			if (pick < 80 && lim == 0) begin
				pick = 86;
			end
			// nothing is too long for the full limit
			if (pick >= 85 && pick < 90 && lim == LEN_CEILING) begin
				pick = 0;
			end
			if (pick < 72) begin
				push_record(fit_len(lim), 1'b0, -1);
			end else if (pick < 80) begin
				push_record(fit_len(lim), 1'b1, -1);
				stopped = 1'b1;
			end else if (pick < 85) begin
				push_header(32'd0, $urandom);
				stopped = 1'b1;
			end else if (pick < 90) begin
				if ($urandom_range(0, 1) == 1) begin
					len = lim + 1;
				end else begin
					len = $urandom_range(lim + 1, LEN_CEILING);
				end
				push_header(len, $urandom);
				stopped = 1'b1;
			end else if (pick < 95) begin
				len = fit_len(lim);
				cut = $urandom_range(1, len + 7);
				push_record(len, 1'b0, cut);
				stopped = 1'b1;
			end else begin
				repeat ($urandom_range(1, 12)) push_byte(8'($urandom));
				stopped = 1'b1;
			end
		end
		if (stopped) begin
			repeat ($urandom_range(0, 6)) push_byte(8'($urandom));
		end
		push_end(8'($urandom));
	endtask

	// ---------------------------------------------------------------
	// Drivers.
	// ---------------------------------------------------------------
	// Offer one transaction, hold it until accepted, then idle at random.
	task automatic send_item(input journal_item_t it);
		int gap;
		in_ch.valid     <= 1'b1;
		in_ch.func      <= it.func;
		in_ch.data_byte <= it.data_byte;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sb.note_item(it.func, it.data_byte);
		in_accepted++;
		gap = next_gap(tx_quiet);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drive and drain the journal queue.
	task automatic drive_journal();
		foreach (journal_q[i]) begin
			send_item(journal_q[i]);
		end
		in_ch.valid <= 1'b0;
		journal_q.delete();
	endtask

	// Hold the sender until every predicted report is in, then let the
	// pipeline run dry, since bytes make no report.
	task automatic wait_idle(input int extra);
		while (sb.pending() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Write the length limit; only called with the block idle.
	task automatic cfg_write(input logic [31:0] v);
		cfg.valid <= 1'b1;
		cfg.data  <= v;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		sb.max_len = v;
	endtask

	// ---------------------------------------------------------------
	// Long hold of the receiver, counted here while the sender keeps going,
	// so the result register and the input stage fill and stall the input.
	// ---------------------------------------------------------------
	initial begin
		wait (arst_n === 1'b1);
		wait (in_accepted >= 300);
		@(posedge clk);
		hold_active <= 1'b1;
		repeat (300) @(posedge clk);
		hold_active <= 1'b0;
	end

	// ---------------------------------------------------------------
	// Result side: check each transaction and stall at random.
	// ---------------------------------------------------------------
	initial begin
		scan_report_t got;
		int           stall_left;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				got.kind          = out_ch.kind;
				got.offset        = out_ch.offset;
				got.record_length = out_ch.record_length;
				got.tail_bytes    = out_ch.tail_bytes;
				got.stop_reason   = out_ch.stop_reason;
				sb.check_report(got);
			end
			if (hold_active) begin
				out_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				stall_left = next_gap(rx_quiet);
				out_ch.ready <= (stall_left == 0);
			end
		end
	end

	// ---------------------------------------------------------------
	// Main sequence: reset, directed journal, then one random phase per
	// length limit, each phase ending idle before the next limit goes in.
	// ---------------------------------------------------------------
	initial begin
		logic [31:0] limits[6];
		in_ch.valid     <= 1'b0;
		in_ch.func      <= FUNC_BYTE;
		in_ch.data_byte <= '0;
		cfg.valid       <= 1'b0;
		cfg.data        <= '0;
		limits = '{rlsv_pkg::MAX_LEN_RESET, 32'd0, 32'd1, LEN_CEILING, 32'd8, 32'd0};
		limits[5] = $urandom_range(1, 64);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty file, smallest good record, zero length with
		// all-ones CRC bytes, then a header cut short inside its CRC.
		push_end(8'hFF);
		push_record(32'd1, 1'b0, -1);
		push_header(32'd0, LEN_CEILING);
		push_end(8'h00);
		repeat (7) push_byte(8'hFF);
		push_end(8'h5A);
		drive_journal();

		foreach (limits[p]) begin
			if (p > 0) begin
				wait_idle(4);
				cfg_write(limits[p]);
			end
			while (journal_q.size() < 167) begin
				gen_file(limits[p]);
			end
			drive_journal();
		end

		wait_idle(8);
		if (sb.failures == 0) begin
			$display("record_log_scan_validator_top verification clean");
		end else begin
			$display("record_log_scan_validator_top verification failed");
		end
		$finish;
	end

	// Run limit, well past the slowest legal run.
	initial begin
		#4_000_000;
		$display("record_log_scan_validator_top verification failed");
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/rlsv_pkg.sv
rtl/rlsv_if.sv
rtl/record_log_scan_validator_top.sv
rtl/rlsv_checker.sv
test/record_log_scan_validator_top_test.sv
